@@ rtl/oida_pkg.sv @@
package oida_pkg;

    // Field widths of the ID layout
    localparam int SLOT_W  = 8;
    localparam int TYPE_W  = 8;
    localparam int CTX_W   = 8;
    localparam int INDEX_W = 40;
    localparam int ID_W    = SLOT_W + TYPE_W + CTX_W + INDEX_W;
    localparam int NIDX_W  = 48;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 3;

    // Free-slot search works on groups of eight slots
    localparam int GROUP_W = 8;
    localparam int OFS_W   = 3;

    localparam int SWITCH_SLOTS_DEF = 255;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_CONTEXT = 2'd0,
        CFG_TYPE_LIMIT     = 2'd1,
        CFG_SWITCH_TYPE    = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] GLOBAL_CONTEXT_RST = 8'd0;
    localparam logic [CFG_W-1:0] TYPE_LIMIT_RST     = 8'd254;
    localparam logic [CFG_W-1:0] SWITCH_TYPE_RST    = 8'd33;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC     = 3'd0,
        REQ_RELEASE   = 3'd1,
        REQ_SWITCH_OF = 3'd2,
        REQ_TYPE_OF   = 3'd3,
        REQ_CLEAR     = 3'd4
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_TYPE    = 3'd1,
        STAT_NO_SLOT     = 3'd2,
        STAT_SLOT_UNUSED = 3'd3,
        STAT_INDEX_OVF   = 3'd4,
        STAT_NOT_SWITCH  = 3'd5
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TYPE_W-1:0] object_type;
        logic [ID_W-1:0]   object_id;
        logic [NIDX_W-1:0] next_index;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [TYPE_W-1:0] result_type;
        logic [STAT_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [CFG_W-1:0] global_context;
        logic [CFG_W-1:0] type_limit;
        logic [CFG_W-1:0] switch_type;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

@@ rtl/oida_ctrl.sv @@
module oida_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output oida_pkg::cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    // Take a request only while nothing is in flight
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Output register is free when empty or drained this cycle
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign cmd.load   = (state_reg == ST_IDLE) && req_valid;
    assign cmd.commit = (state_reg == ST_COMMIT) && out_free;

    // Next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ rtl/oida_dp.sv @@
module oida_dp #(
    parameter int SWITCH_SLOTS = oida_pkg::SWITCH_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  oida_pkg::cmd_t  cmd,
    input  oida_pkg::cfg_t  cfg,
    input  oida_pkg::req_t  req_data,
    output oida_pkg::rsp_t  rsp_data
);

    localparam int GROUP_W    = oida_pkg::GROUP_W;
    localparam int OFS_W      = oida_pkg::OFS_W;
    localparam int SLOT_W     = oida_pkg::SLOT_W;
    localparam int TYPE_W     = oida_pkg::TYPE_W;
    localparam int NUM_GROUPS = (SWITCH_SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W      = NUM_GROUPS * GROUP_W;
    localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    logic [SWITCH_SLOTS-1:0] slot_used_reg;
    logic [SWITCH_SLOTS-1:0] slot_used_next;
    logic [PAD_W-1:0]        free_pad;
    logic [NUM_GROUPS-1:0]   grp_any;
    logic [GIDX_W-1:0]       grp_idx_reg;
    logic [GIDX_W-1:0]       grp_idx_next;
    logic                    grp_found_reg;
    logic                    grp_found_next;
    oida_pkg::req_t          req_reg;
    oida_pkg::rsp_t          rsp_reg;
    oida_pkg::rsp_t          rsp_next;
    logic                    map_set;
    logic                    map_clr;
    logic                    map_wipe;
    logic [SLOT_W-1:0]       set_slot;
    logic [SLOT_W-1:0]       clr_slot;

    // Type field of an ID, zero when the ID is null or the type invalid
    function automatic logic [TYPE_W-1:0] decode_type(
        input logic [oida_pkg::ID_W-1:0] id,
        input logic [TYPE_W-1:0]         limit
    );
        logic [TYPE_W-1:0] t;
        t = id[oida_pkg::ID_W-SLOT_W-1 -: TYPE_W];
        if (id == '0 || t == '0 || t >= limit)
        begin
            return '0;
        end
        return t;
    endfunction

    // Free map, slots past the end count as used
    always_comb
    begin
        free_pad                   = '0;
        free_pad[SWITCH_SLOTS-1:0] = ~slot_used_reg;
    end

    always_comb
    begin
        grp_any = '0;
        for (int j = 0; j < NUM_GROUPS; j++)
        begin
            grp_any[j] = |free_pad[j*GROUP_W +: GROUP_W];
        end
    end

    // Lowest group that still has a free slot
    always_comb
    begin
        grp_idx_next   = '0;
        grp_found_next = 1'b0;
        for (int j = NUM_GROUPS - 1; j >= 0; j--)
        begin
            if (grp_any[j])
            begin
                grp_found_next = 1'b1;
                grp_idx_next   = GIDX_W'(j);
            end
        end
    end

    // Latch request and search result
    always_ff @(posedge clk)
    begin
        grp_idx_reg   <= grp_idx_next;
        grp_found_reg <= grp_found_next;
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Execute the request held in req_reg
    always_comb
    begin
        logic [GROUP_W-1:0]               sel_bits;
        logic [OFS_W-1:0]                 ofs;
        logic [SLOT_W-1:0]                alloc_slot;
        logic [SLOT_W-1:0]                id_slot;
        logic [TYPE_W-1:0]                otype;
        logic [TYPE_W-1:0]                dtype;
        logic [oida_pkg::ID_W-1:0]        oid;
        logic                             slot_hit;

        sel_bits = '0;
        for (int j = 0; j < NUM_GROUPS; j++)
        begin
            if (GIDX_W'(j) == grp_idx_reg)
            begin
                sel_bits = free_pad[j*GROUP_W +: GROUP_W];
            end
        end
        ofs = '0;
        for (int b = GROUP_W - 1; b >= 0; b--)
        begin
            if (sel_bits[b])
            begin
                ofs = OFS_W'(b);
            end
        end
        alloc_slot = SLOT_W'({grp_idx_reg, ofs});

        oid     = req_reg.object_id;
        otype   = req_reg.object_type;
        id_slot = oid[oida_pkg::ID_W-1 -: SLOT_W];
        dtype   = decode_type(oid, cfg.type_limit);

        slot_hit = 1'b0;
        for (int i = 0; i < SWITCH_SLOTS; i++)
        begin
            if (SLOT_W'(i) == id_slot)
            begin
                slot_hit = slot_used_reg[i];
            end
        end

        rsp_next = '0;
        map_set  = 1'b0;
        map_clr  = 1'b0;
        map_wipe = 1'b0;
        set_slot = alloc_slot;
        clr_slot = id_slot;

        case (req_reg.req_type)
            oida_pkg::REQ_ALLOC:
            begin
                if (otype == '0 || otype >= cfg.type_limit)
                begin
                    rsp_next.status = oida_pkg::STAT_BAD_TYPE;
                end
                else if (otype == cfg.switch_type)
                begin
                    if (grp_found_reg)
                    begin
                        map_set            = 1'b1;
                        rsp_next.result_id = {alloc_slot, cfg.switch_type,
                                              cfg.global_context,
                                              oida_pkg::INDEX_W'(alloc_slot)};
                    end
                    else
                    begin
                        rsp_next.status = oida_pkg::STAT_NO_SLOT;
                    end
                end
                else if (dtype != cfg.switch_type)
                begin
                    rsp_next.status = oida_pkg::STAT_NOT_SWITCH;
                end
                else if (req_reg.next_index[oida_pkg::NIDX_W-1:oida_pkg::INDEX_W] != '0)
                begin
                    rsp_next.status = oida_pkg::STAT_INDEX_OVF;
                end
                else
                begin
                    rsp_next.result_id = {id_slot, otype, cfg.global_context,
                                          req_reg.next_index[oida_pkg::INDEX_W-1:0]};
                end
            end
            oida_pkg::REQ_RELEASE:
            begin
                if (dtype == cfg.switch_type)
                begin
                    if (id_slot >= SLOT_W'(SWITCH_SLOTS) || !slot_hit)
                    begin
                        rsp_next.status = oida_pkg::STAT_SLOT_UNUSED;
                    end
                    else
                    begin
                        map_clr = 1'b1;
                    end
                end
            end
            oida_pkg::REQ_SWITCH_OF:
            begin
                if (oid != '0)
                begin
                    if (dtype == '0)
                    begin
                        rsp_next.status = oida_pkg::STAT_BAD_TYPE;
                    end
                    else if (dtype == cfg.switch_type)
                    begin
                        rsp_next.result_id = oid;
                    end
                    else
                    begin
                        rsp_next.result_id = {id_slot, cfg.switch_type,
                                              oid[oida_pkg::INDEX_W +: oida_pkg::CTX_W],
                                              oida_pkg::INDEX_W'(id_slot)};
                    end
                end
            end
            oida_pkg::REQ_TYPE_OF:
            begin
                rsp_next.result_type = dtype;
            end
            oida_pkg::REQ_CLEAR:
            begin
                map_wipe = 1'b1;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Next used-map: set, free or wipe
    always_comb
    begin
        slot_used_next = slot_used_reg;
        for (int i = 0; i < SWITCH_SLOTS; i++)
        begin
            if (map_set && SLOT_W'(i) == set_slot)
            begin
                slot_used_next[i] = 1'b1;
            end
            if (map_clr && SLOT_W'(i) == clr_slot)
            begin
                slot_used_next[i] = 1'b0;
            end
        end
        if (map_wipe)
        begin
            slot_used_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
        end
        else if (cmd.commit)
        begin
            slot_used_reg <= slot_used_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

@@ rtl/object_id_allocator_core.sv @@
// Object ID allocator: mints 64-bit IDs laid out as slot[63:56], type[55:48],
// context[47:40], index[39:0], keeps a used-map of switch slots and decodes
// IDs for type and owning-switch queries. One request is in flight at a time:
// the cycle that accepts a request also registers the lowest group of eight
// slots with a free entry, and the commit state, once the output register is
// free, picks the slot inside that group, updates the map and loads the
// response register. The next request is taken while a response still waits
// to be drained. The map clears at reset with no sweep. Write configuration
// only while no request is in flight.
module object_id_allocator_core #(
    parameter int SWITCH_SLOTS = oida_pkg::SWITCH_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  oida_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output oida_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oida_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [oida_pkg::CFG_W-1:0]        cfg_data
);

    oida_pkg::cmd_t          cmd;
    oida_pkg::cfg_t          cfg;
    logic [oida_pkg::CFG_W-1:0] global_context_reg;
    logic [oida_pkg::CFG_W-1:0] type_limit_reg;
    logic [oida_pkg::CFG_W-1:0] switch_type_reg;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_context_reg <= oida_pkg::GLOBAL_CONTEXT_RST;
            type_limit_reg     <= oida_pkg::TYPE_LIMIT_RST;
            switch_type_reg    <= oida_pkg::SWITCH_TYPE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                oida_pkg::CFG_GLOBAL_CONTEXT: global_context_reg <= cfg_data;
                oida_pkg::CFG_TYPE_LIMIT:     type_limit_reg     <= cfg_data;
                oida_pkg::CFG_SWITCH_TYPE:    switch_type_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign cfg.global_context = global_context_reg;
    assign cfg.type_limit     = type_limit_reg;
    assign cfg.switch_type    = switch_type_reg;

    oida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    oida_dp #(
        .SWITCH_SLOTS (SWITCH_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

    // One transaction in flight: an accepted request blocks the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted back to back");

    // A response only appears after a request was being worked on
    a_rsp_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without request");

    // Errors carry zero result fields
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != oida_pkg::STAT_OK) |->
        (rsp_data.result_id == '0 && rsp_data.result_type == '0))
        else $error("error response with nonzero result");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status <= oida_pkg::STAT_NOT_SWITCH))
        else $error("undefined status code");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int REQ_W     = oida_pkg::REQ_W;
    localparam int ID_W      = oida_pkg::ID_W;
    localparam int INDEX_W   = oida_pkg::INDEX_W;
    localparam int TYPE_W    = oida_pkg::TYPE_W;
    localparam int NIDX_W    = oida_pkg::NIDX_W;
    localparam int CFG_IDX_W = oida_pkg::CFG_IDX_W;
    localparam int CFG_W     = oida_pkg::CFG_W;

    localparam int NSLOTS          = oida_pkg::SWITCH_SLOTS_DEF;
    localparam int ITEMS_PER_PHASE = 80;

    // Request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    // IDs used by the directed table at reset configuration
    localparam logic [ID_W-1:0] SW_ID0  = 64'h0021_0000_0000_0000;
    localparam logic [ID_W-1:0] SW_ID1  = 64'h0121_0000_0000_0001;
    localparam logic [ID_W-1:0] OBJ_ID  = 64'h0105_00FF_FFFF_FFFF;
    localparam logic [ID_W-1:0] SW_ID_HI = 64'hFF21_0000_0000_00FF;

    typedef struct {
        oida_pkg::req_t item;
        bit             pin;
        oida_pkg::rsp_t rsp;
    } case_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    oida_pkg::req_t       req_data;
    logic                 rsp_valid;
    logic                 rsp_stall;
    oida_pkg::rsp_t       rsp_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow of the block's configuration and slot map
    logic [CFG_W-1:0] ctx_reg;
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] sw_reg;
    bit   [255:0]     slot_taken;

    oida_pkg::rsp_t expected_q[$];
    bit             pin_exp;
    oida_pkg::rsp_t pinned_rsp;
    bit             quiet;
    int             n_sent;
    int             n_checked;
    int             n_errors;
    int             n_settings;
    int             n_fills;

    object_id_allocator_core #(
        .SWITCH_SLOTS(NSLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [ID_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] pack_id(logic [7:0] slot, logic [7:0] otype,
                                                 logic [7:0] ctx, logic [INDEX_W-1:0] idx);
        return {slot, otype, ctx, idx};
    endfunction

    // Zero for a null ID or a type field outside 1..limit-1
    function automatic logic [TYPE_W-1:0] decoded_type(logic [ID_W-1:0] id);
        logic [TYPE_W-1:0] t;
        t = id[55:48];
        if (id == '0 || t == '0 || t >= limit_reg)
            return '0;
        return t;
    endfunction

    // Compute the response to one request and advance the slot map
    function automatic oida_pkg::rsp_t predict(oida_pkg::req_t r);
        oida_pkg::rsp_t    o;
        logic [7:0]        slot;
        logic [TYPE_W-1:0] t;
        o = '0;
        slot = r.object_id[63:56];
        case (r.req_type)
            oida_pkg::REQ_ALLOC:
            begin
                if (r.object_type == '0 || r.object_type >= limit_reg)
                    o.status = oida_pkg::STAT_BAD_TYPE;
                else if (r.object_type == sw_reg)
                begin
                    o.status = oida_pkg::STAT_NO_SLOT;
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        if (!slot_taken[i])
                        begin
                            slot_taken[i] = 1'b1;
                            o.result_id = pack_id(8'(i), sw_reg, ctx_reg, 40'(i));
                            o.status = oida_pkg::STAT_OK;
                            break;
                        end
                    end
                end
                else if (decoded_type(r.object_id) != sw_reg)
                    o.status = oida_pkg::STAT_NOT_SWITCH;
                else if (r.next_index[NIDX_W-1:INDEX_W] != '0)
                    o.status = oida_pkg::STAT_INDEX_OVF;
                else
                    o.result_id = pack_id(slot, r.object_type, ctx_reg,
                                          r.next_index[INDEX_W-1:0]);
            end
            oida_pkg::REQ_RELEASE:
            begin
                if (decoded_type(r.object_id) == sw_reg)
                begin
                    if (slot >= NSLOTS || !slot_taken[slot])
                        o.status = oida_pkg::STAT_SLOT_UNUSED;
                    else
                        slot_taken[slot] = 1'b0;
                end
            end
            oida_pkg::REQ_SWITCH_OF:
            begin
                if (r.object_id != '0)
                begin
                    t = decoded_type(r.object_id);
                    if (t == '0)
                        o.status = oida_pkg::STAT_BAD_TYPE;
                    else if (t == sw_reg)
                        o.result_id = r.object_id;
                    else
                        o.result_id = pack_id(slot, sw_reg, r.object_id[47:40], 40'(slot));
                end
            end
            oida_pkg::REQ_TYPE_OF:
                o.result_type = decoded_type(r.object_id);
            oida_pkg::REQ_CLEAR:
                slot_taken = '0;
            default:
                o = '0;
        endcase
        return o;
    endfunction

    function automatic oida_pkg::req_t make_req(logic [REQ_W-1:0] code,
                                                logic [TYPE_W-1:0] otype,
                                                logic [ID_W-1:0] oid,
                                                logic [NIDX_W-1:0] nidx);
        oida_pkg::req_t it;
        it.req_type    = code;
        it.object_type = otype;
        it.object_id   = oid;
        it.next_index  = nidx;
        return it;
    endfunction

    function automatic case_row_t case_row(logic [REQ_W-1:0] code, logic [TYPE_W-1:0] otype,
                                           logic [ID_W-1:0] oid, logic [NIDX_W-1:0] nidx,
                                           bit pin, logic [ID_W-1:0] rid,
                                           logic [TYPE_W-1:0] rtype, oida_pkg::status_t st);
        case_row_t c;
        c.item = make_req(code, otype, oid, nidx);
        c.pin = pin;
        c.rsp.result_id = rid;
        c.rsp.result_type = rtype;
        c.rsp.status = st;
        return c;
    endfunction

    function automatic logic [TYPE_W-1:0] valid_type();
        return 8'($urandom_range(1, limit_reg - 1));
    endfunction

    // Mostly a slot in use, sometimes any slot including the one past the end
    function automatic logic [7:0] pick_slot();
        int start;
        start = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0)
        begin
            for (int k = 0; k < 256; k++)
            begin
                if (slot_taken[(start + k) % 256])
                    return 8'((start + k) % 256);
            end
        end
        return 8'(start);
    endfunction

    function automatic logic [ID_W-1:0] switch_id(logic [7:0] slot);
        return pack_id(slot, sw_reg, 8'($urandom), 40'(rand64()));
    endfunction

    function automatic logic [ID_W-1:0] query_id();
        case ($urandom_range(0, 5))
            0, 1: return switch_id(pick_slot());
            2: return pack_id(8'($urandom), valid_type(), 8'($urandom), 40'(rand64()));
            3: return pack_id(8'($urandom), ($urandom_range(0, 1) != 0) ? limit_reg : 8'd0,
                              8'($urandom), 40'(rand64()));
            4: return '0;
            default: return rand64();
        endcase
    endfunction

    // Mostly well-formed requests against live slots, the rest noise
    function automatic oida_pkg::req_t gen_item();
        oida_pkg::req_t it;
        int             pick;
        it = make_req(oida_pkg::REQ_ALLOC, 8'($urandom), rand64(), 48'(rand64()));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.object_type = sw_reg;
        else if (pick < 50)
        begin
            it.object_type = ($urandom_range(0, 9) == 0) ? 8'($urandom) : valid_type();
            it.object_id = ($urandom_range(0, 9) == 0) ? query_id() : switch_id(pick_slot());
            if ($urandom_range(0, 4) != 0)
                it.next_index[NIDX_W-1:INDEX_W] = '0;
        end
        else if (pick < 65)
        begin
            it.req_type = oida_pkg::REQ_RELEASE;
            if ($urandom_range(0, 6) != 0)
                it.object_id = switch_id(pick_slot());
        end
        else if (pick < 75)
        begin
            it.req_type = oida_pkg::REQ_SWITCH_OF;
            it.object_id = query_id();
        end
        else if (pick < 85)
        begin
            it.req_type = oida_pkg::REQ_TYPE_OF;
            it.object_id = query_id();
        end
        else if (pick < 88)
            it.req_type = oida_pkg::REQ_CLEAR;
        else
            it.req_type = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // Score responses, track register writes, queue predictions
    always @(posedge clk)
    begin : score
        oida_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (n_errors < 10)
                        $display("%0t: response with none outstanding: id %h type %h status %0d",
                                 $time, rsp_data.result_id, rsp_data.result_type,
                                 rsp_data.status);
                    n_errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_data.result_id !== want.result_id ||
                        rsp_data.result_type !== want.result_type ||
                        rsp_data.status !== want.status)
                    begin
                        if (n_errors < 10)
                            $display("%0t: response %0d: id %h/%h type %h/%h status %0d/%0d %s",
                                     $time, n_checked, want.result_id, rsp_data.result_id,
                                     want.result_type, rsp_data.result_type, want.status,
                                     rsp_data.status, "(expected/actual)");
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    oida_pkg::CFG_GLOBAL_CONTEXT: ctx_reg = cfg_data;
                    oida_pkg::CFG_TYPE_LIMIT:     limit_reg = cfg_data;
                    oida_pkg::CFG_SWITCH_TYPE:    sw_reg = cfg_data;
                    default:                      ctx_reg = ctx_reg;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                want = predict(req_data);
                if (pin_exp)
                    want = pinned_rsp;
                expected_q.push_back(want);
                n_sent++;
            end
        end
    end

    // Stall the response side in random bursts, none once quiet
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_stall = !quiet && ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
    end

    // Present one request transaction and hold it until accepted
    task automatic send_item(oida_pkg::req_t item, bit pin, oida_pkg::rsp_t pinned);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_data = item;
        pin_exp = pin;
        pinned_rsp = pinned;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        pin_exp = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(oida_pkg::cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] ctx, logic [CFG_W-1:0] limit,
                              logic [CFG_W-1:0] sw);
        drain();
        write_reg(oida_pkg::CFG_GLOBAL_CONTEXT, ctx);
        write_reg(oida_pkg::CFG_TYPE_LIMIT, limit);
        write_reg(oida_pkg::CFG_SWITCH_TYPE, sw);
        cfg_valid = 1'b0;
        n_settings++;
    endtask

    // Allocate past a full map, free and refill a few slots, then clear
    task automatic fill_map();
        logic [7:0] slot;
        for (int k = 0; k < NSLOTS + 2; k++)
            send_item(make_req(oida_pkg::REQ_ALLOC, sw_reg, rand64(), 48'(rand64())),
                      1'b0, '0);
        for (int k = 0; k < 4; k++)
        begin
            slot = (k == 0) ? 8'(NSLOTS - 1) : 8'($urandom_range(0, NSLOTS - 1));
            send_item(make_req(oida_pkg::REQ_RELEASE, 8'($urandom), switch_id(slot),
                               48'(rand64())), 1'b0, '0);
            send_item(make_req(oida_pkg::REQ_ALLOC, sw_reg, rand64(), 48'(rand64())),
                      1'b0, '0);
        end
        send_item(make_req(oida_pkg::REQ_ALLOC, sw_reg, rand64(), 48'(rand64())), 1'b0, '0);
        send_item(make_req(oida_pkg::REQ_CLEAR, 8'($urandom), rand64(), 48'(rand64())),
                  1'b0, '0);
        n_fills++;
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(gen_item(), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        case_row_t rows[$];
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_valid = 1'b0;
        cfg_index = oida_pkg::CFG_GLOBAL_CONTEXT;
        cfg_data = '0;
        pin_exp = 1'b0;
        pinned_rsp = '0;
        quiet = 1'b0;
        ctx_reg = oida_pkg::GLOBAL_CONTEXT_RST;
        limit_reg = oida_pkg::TYPE_LIMIT_RST;
        sw_reg = oida_pkg::SWITCH_TYPE_RST;
        slot_taken = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_settings = 0;
        n_fills = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed cases at reset configuration: context 0, limit 254, switch type 33
        rows = '{
            case_row(oida_pkg::REQ_TYPE_OF, 8'd0, '0, '0, 1'b1, '0, 8'd0, oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_SWITCH_OF, 8'd0, '0, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_ALLOC, 8'd33, '0, '0, 1'b1, SW_ID0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_ALLOC, 8'd33, '1, '1, 1'b1, SW_ID1, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_ALLOC, 8'd0, SW_ID0, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_BAD_TYPE),
            case_row(oida_pkg::REQ_ALLOC, 8'd254, SW_ID0, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_BAD_TYPE),
            case_row(oida_pkg::REQ_ALLOC, 8'd255, '1, '1, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_BAD_TYPE),
            case_row(oida_pkg::REQ_ALLOC, 8'd5, SW_ID1, 48'h00FF_FFFF_FFFF, 1'b1, OBJ_ID,
                     8'd0, oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_ALLOC, 8'd5, SW_ID1, 48'h0100_0000_0000, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_INDEX_OVF),
            case_row(oida_pkg::REQ_ALLOC, 8'd5, SW_ID1, '1, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_INDEX_OVF),
            case_row(oida_pkg::REQ_ALLOC, 8'd5, OBJ_ID, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_NOT_SWITCH),
            case_row(oida_pkg::REQ_ALLOC, 8'd253, SW_ID0, '0, 1'b0, '0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_TYPE_OF, 8'd0, OBJ_ID, '0, 1'b1, '0, 8'd5,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_TYPE_OF, 8'd0, 64'h01FE_0000_0000_0001, '0, 1'b1, '0,
                     8'd0, oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_TYPE_OF, 8'd0, 64'h00FD_0000_0000_0000, '0, 1'b1, '0,
                     8'd253, oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_SWITCH_OF, 8'd0, OBJ_ID, '0, 1'b0, '0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_SWITCH_OF, 8'd0, SW_ID1, '0, 1'b1, SW_ID1, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_SWITCH_OF, 8'd0, 64'hFF00_FFFF_FFFF_FFFF, '0, 1'b1, '0,
                     8'd0, oida_pkg::STAT_BAD_TYPE),
            case_row(oida_pkg::REQ_RELEASE, 8'd0, SW_ID0, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_RELEASE, 8'd0, SW_ID0, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_SLOT_UNUSED),
            case_row(oida_pkg::REQ_RELEASE, 8'd0, OBJ_ID, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_RELEASE, 8'd0, SW_ID_HI, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_SLOT_UNUSED),
            case_row(oida_pkg::REQ_ALLOC, 8'd33, '0, '0, 1'b1, SW_ID0, 8'd0,
                     oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_CLEAR, 8'd0, '0, '0, 1'b1, '0, 8'd0, oida_pkg::STAT_OK),
            case_row(oida_pkg::REQ_RELEASE, 8'd0, SW_ID1, '0, 1'b1, '0, 8'd0,
                     oida_pkg::STAT_SLOT_UNUSED),
            case_row(REQ_RSVD_LO, 8'hFF, '1, '1, 1'b1, '0, 8'd0, oida_pkg::STAT_OK),
            case_row(REQ_RSVD_HI, 8'hFF, '1, '1, 1'b1, '0, 8'd0, oida_pkg::STAT_OK)
        };
        foreach (rows[r])
            send_item(rows[r].item, rows[r].pin, rows[r].rsp);
        drain();
        fill_map();

        // Random phases over several register settings, extremes first
        set_config(8'hFF, 8'd254, 8'd253);
        fill_map();
        run_random(ITEMS_PER_PHASE);
        set_config(8'h00, 8'd2, 8'd1);
        fill_map();
        run_random(ITEMS_PER_PHASE);
        set_config(8'h5A, 8'd100, 8'd200);
        run_random(ITEMS_PER_PHASE);
        set_config(8'($urandom), 8'($urandom_range(2, 254)), 8'($urandom_range(1, 253)));
        run_random(ITEMS_PER_PHASE);
        set_config(8'hA5, 8'd40, 8'd33);
        run_random(ITEMS_PER_PHASE);
        quiet = 1'b1;
        set_config(oida_pkg::GLOBAL_CONTEXT_RST, oida_pkg::TYPE_LIMIT_RST,
                   oida_pkg::SWITCH_TYPE_RST);
        run_random(ITEMS_PER_PHASE);
        drain();
        repeat (10) @(posedge clk);

        $display("Run covered %0d requests and %0d checked responses over %0d settings,",
                 n_sent, n_checked, n_settings);
        $display("with %0d full-map sweeps; %0d mismatches, %0d responses missing",
                 n_fills, n_errors, expected_q.size());
        if (n_errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d responses outstanding", expected_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
